// ----- sv/lfo_pan_pkg.sv -----
// Package with the shared constants, types and sine table of the auto-panner.
`timescale 1ns / 1ps
package lfo_pan_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 8;

    localparam int FRAC_BITS = 15;
    localparam int SINE_W    = 15;
    localparam int GAIN_W    = 16;
    localparam int PSTEP_W   = 20;
    localparam int WIDTH_W   = 16;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int STREAM_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    localparam int MCAND_W = (SAMPLE_BITS > SINE_W) ? SAMPLE_BITS : SINE_W;
    localparam int PROD_W  = MCAND_W + GAIN_W;
    localparam int RND_W   = PROD_W + 1 - FRAC_BITS;
    localparam int CNT_W   = $clog2(GAIN_W);
    localparam int SINE_N  = 1 << SINE_TABLE_BITS;

    localparam logic [GAIN_W-1:0]  GAIN_ONE    = GAIN_W'(1 << FRAC_BITS);
    localparam logic [SINE_W-1:0]  SINE_MAX    = '1;
    localparam logic [PSTEP_W-1:0] PSTEP_RESET = PSTEP_W'(44739);
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(24576);

    localparam logic REG_PHASE_STEP = 1'b0;
    localparam logic REG_WIDTH      = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAN_GO,
        ST_PAN_WAIT,
        ST_CH_GO,
        ST_CH_WAIT,
        ST_OUT
    } pan_state_t;

    typedef logic [SINE_N-1:0][SINE_W-1:0] sine_table_t;

    function automatic sine_table_t build_sine_table();
        sine_table_t t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] s;
        for (int k = 0; k < SINE_N; k++) begin
            x  = 64'(k) << (30 - SINE_TABLE_BITS);
            x2 = (x * x) >> 30;
            p  = 64'd172272;
            p  = 64'd5026995 - ((x2 * p) >> 30);
            p  = 64'd85569305 - ((x2 * p) >> 30);
            p  = 64'd693598669 - ((x2 * p) >> 30);
            p  = 64'd1686629713 - ((x2 * p) >> 30);
            s  = (x * p) >> 30;
            s  = (s + 64'd16384) >> 15;
            if (s > 64'd32767)
            begin
                s = 64'd32767;
            end
            t[k] = s[SINE_W-1:0];
        end
        return t;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

    function automatic logic [RND_W-1:0] round_q15(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] s;
        s = {1'b0, p} + (PROD_W + 1)'(1 << (FRAC_BITS - 1));
        return s[PROD_W:FRAC_BITS];
    endfunction

endpackage

// ----- sv/lfo_pan_sine.sv -----
// Quarter-wave sine lookup that turns the LFO phase into a sign and a Q0.15 magnitude.
`timescale 1ns / 1ps
module lfo_pan_sine (
    input  logic [lfo_pan_pkg::PHASE_BITS-1:0]      phase,
    output logic [lfo_pan_pkg::SINE_W-1:0]          sine_mag,
    output logic                                    sine_neg
);

    logic [1:0]                                quad;
    logic [lfo_pan_pkg::SINE_TABLE_BITS-1:0]   idx;
    logic [lfo_pan_pkg::SINE_TABLE_BITS-1:0]   idx_mirror;

    assign quad       = phase[lfo_pan_pkg::PHASE_BITS-1 -: 2];
    assign idx        = phase[lfo_pan_pkg::PHASE_BITS-3 -: lfo_pan_pkg::SINE_TABLE_BITS];
    assign idx_mirror = lfo_pan_pkg::SINE_TABLE_BITS'(~idx + 1'b1);
    assign sine_neg   = quad[1];

    always_comb
    begin
        if (!quad[0])
        begin
            sine_mag = lfo_pan_pkg::SINE_TABLE[idx];
        end
        else if (idx == '0)
        begin
            sine_mag = lfo_pan_pkg::SINE_MAX;
        end
        else
        begin
            sine_mag = lfo_pan_pkg::SINE_TABLE[idx_mirror];
        end
    end

endmodule

// ----- sv/lfo_pan_ser_mul.sv -----
// Bit-serial shift-add multiplier that consumes one multiplier bit per cycle.
`timescale 1ns / 1ps
module lfo_pan_ser_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [lfo_pan_pkg::MCAND_W-1:0]     mcand,
    input  logic [lfo_pan_pkg::GAIN_W-1:0]      mplier,
    output logic                                done,
    output logic [lfo_pan_pkg::PROD_W-1:0]      product
);

    logic                               busy_reg;
    logic                               busy_next;
    logic                               done_reg;
    logic                               done_next;
    logic [lfo_pan_pkg::CNT_W-1:0]      cnt_reg;
    logic [lfo_pan_pkg::CNT_W-1:0]      cnt_next;
    logic [lfo_pan_pkg::MCAND_W-1:0]    mcand_reg;
    logic [lfo_pan_pkg::MCAND_W-1:0]    mcand_next;
    logic [lfo_pan_pkg::PROD_W-1:0]     prod_reg;
    logic [lfo_pan_pkg::PROD_W-1:0]     prod_next;
    logic [lfo_pan_pkg::MCAND_W:0]      sum;

    assign sum = {1'b0, prod_reg[lfo_pan_pkg::PROD_W-1:lfo_pan_pkg::GAIN_W]}
               + {1'b0, (prod_reg[0] ? mcand_reg : '0)};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        prod_next  = prod_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            mcand_next = mcand;
            prod_next  = {{lfo_pan_pkg::MCAND_W{1'b0}}, mplier};
        end
        else if (busy_reg)
        begin
            prod_next = {sum, prod_reg[lfo_pan_pkg::GAIN_W-1:1]};
            cnt_next  = lfo_pan_pkg::CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == lfo_pan_pkg::CNT_W'(lfo_pan_pkg::GAIN_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

// ----- sv/lfo_stereo_auto_panner_core.sv -----
// A pair runs through PAN_GO, PAN_WAIT, CH_GO, CH_WAIT and OUT into the output register.
// A new pair is taken only in IDLE, after two bit-serial multiply rounds run in turn.
// The pan multiply runs first; the left and right multiplies then run side by side.
// A finished result waits in the output register while the next pair is taken.
// Reset clears the LFO phase, loads the register defaults and empties the pipeline.
// Top level of the sine LFO stereo auto-panner with its register port and stream ports.
`timescale 1ns / 1ps
module lfo_stereo_auto_panner_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [lfo_pan_pkg::ADDR_W-1:0]          paddr,
    input  logic [lfo_pan_pkg::DATA_W-1:0]          pwdata,
    output logic [lfo_pan_pkg::DATA_W-1:0]          prdata,
    output logic                                    pready,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // Fields from bit 0: left_in, right_in.
    input  logic [lfo_pan_pkg::STREAM_W-1:0]        s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // Fields from bit 0: left_out, right_out.
    output logic [lfo_pan_pkg::STREAM_W-1:0]        m_tdata
);

    localparam int SB = lfo_pan_pkg::SAMPLE_BITS;

    lfo_pan_pkg::pan_state_t                state_reg;
    lfo_pan_pkg::pan_state_t                state_next;

    logic [lfo_pan_pkg::PHASE_BITS-1:0]     phase_reg;
    logic [lfo_pan_pkg::PHASE_BITS-1:0]     phase_next;
    logic [lfo_pan_pkg::PSTEP_W-1:0]        phase_step_reg;
    logic [lfo_pan_pkg::WIDTH_W-1:0]        width_reg;

    logic [lfo_pan_pkg::SINE_W-1:0]         sine_mag;
    logic                                   sine_neg;
    logic [lfo_pan_pkg::SINE_W-1:0]         sine_mag_reg;
    logic                                   sine_neg_reg;

    logic [SB-1:0]                          left_in;
    logic [SB-1:0]                          right_in;
    logic [SB-1:0]                          l_mag_reg;
    logic [SB-1:0]                          r_mag_reg;
    logic                                   l_neg_reg;
    logic                                   r_neg_reg;

    logic [lfo_pan_pkg::GAIN_W-1:0]         gain_l_reg;
    logic [lfo_pan_pkg::GAIN_W-1:0]         gain_r_reg;
    logic [lfo_pan_pkg::GAIN_W-1:0]         pan_mag;
    logic [lfo_pan_pkg::RND_W-1:0]          pan_rnd;
    logic [lfo_pan_pkg::RND_W-1:0]          l_rnd;
    logic [lfo_pan_pkg::RND_W-1:0]          r_rnd;
    logic [SB-1:0]                          l_trunc;
    logic [SB-1:0]                          r_trunc;
    logic [SB-1:0]                          left_out;
    logic [SB-1:0]                          right_out;

    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic [lfo_pan_pkg::STREAM_W-1:0]       out_data_reg;

    logic                                   load_in;
    logic                                   load_gain;
    logic                                   load_out;
    logic                                   start_a;
    logic                                   start_b;
    logic                                   cfg_write;

    logic [lfo_pan_pkg::MCAND_W-1:0]        mcand_a;
    logic [lfo_pan_pkg::GAIN_W-1:0]         mplier_a;
    logic                                   done_a;
    logic                                   done_b;
    logic [lfo_pan_pkg::PROD_W-1:0]         prod_a;
    logic [lfo_pan_pkg::PROD_W-1:0]         prod_b;

    assign left_in  = s_tdata[SB-1:0];
    assign right_in = s_tdata[2*SB-1:SB];

    lfo_pan_sine u_sine (
        .phase    (phase_reg),
        .sine_mag (sine_mag),
        .sine_neg (sine_neg)
    );

    assign mcand_a  = (state_reg == lfo_pan_pkg::ST_PAN_GO)
                    ? lfo_pan_pkg::MCAND_W'(sine_mag_reg)
                    : lfo_pan_pkg::MCAND_W'(l_mag_reg);
    assign mplier_a = (state_reg == lfo_pan_pkg::ST_PAN_GO) ? width_reg : gain_l_reg;

    lfo_pan_ser_mul u_mul_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_a),
        .mcand   (mcand_a),
        .mplier  (mplier_a),
        .done    (done_a),
        .product (prod_a)
    );

    lfo_pan_ser_mul u_mul_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_b),
        .mcand   (lfo_pan_pkg::MCAND_W'(r_mag_reg)),
        .mplier  (gain_r_reg),
        .done    (done_b),
        .product (prod_b)
    );

    assign pan_rnd = lfo_pan_pkg::round_q15(prod_a);
    assign pan_mag = (pan_rnd > lfo_pan_pkg::RND_W'(lfo_pan_pkg::GAIN_ONE))
                   ? lfo_pan_pkg::GAIN_ONE
                   : pan_rnd[lfo_pan_pkg::GAIN_W-1:0];

    assign l_rnd     = lfo_pan_pkg::round_q15(prod_a);
    assign r_rnd     = lfo_pan_pkg::round_q15(prod_b);
    assign l_trunc   = l_rnd[SB-1:0];
    assign r_trunc   = r_rnd[SB-1:0];
    assign left_out  = l_neg_reg ? SB'(~l_trunc + 1'b1) : l_trunc;
    assign right_out = r_neg_reg ? SB'(~r_trunc + 1'b1) : r_trunc;

    assign phase_next = lfo_pan_pkg::PHASE_BITS'(phase_reg
                      + lfo_pan_pkg::PHASE_BITS'(phase_step_reg));

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        load_in    = 1'b0;
        load_gain  = 1'b0;
        load_out   = 1'b0;
        start_a    = 1'b0;
        start_b    = 1'b0;
        unique case (state_reg)
            lfo_pan_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    load_in    = 1'b1;
                    state_next = lfo_pan_pkg::ST_PAN_GO;
                end
            end
            lfo_pan_pkg::ST_PAN_GO:
            begin
                start_a    = 1'b1;
                state_next = lfo_pan_pkg::ST_PAN_WAIT;
            end
            lfo_pan_pkg::ST_PAN_WAIT:
            begin
                if (done_a)
                begin
                    load_gain  = 1'b1;
                    state_next = lfo_pan_pkg::ST_CH_GO;
                end
            end
            lfo_pan_pkg::ST_CH_GO:
            begin
                start_a    = 1'b1;
                start_b    = 1'b1;
                state_next = lfo_pan_pkg::ST_CH_WAIT;
            end
            lfo_pan_pkg::ST_CH_WAIT:
            begin
                if (done_a)
                begin
                    state_next = lfo_pan_pkg::ST_OUT;
                end
            end
            lfo_pan_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = lfo_pan_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfo_pan_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lfo_pan_pkg::ST_IDLE;
            phase_reg      <= '0;
            phase_step_reg <= lfo_pan_pkg::PSTEP_RESET;
            width_reg      <= lfo_pan_pkg::WIDTH_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (load_in)
            begin
                phase_reg <= phase_next;
            end
            if (cfg_write)
            begin
                unique case (paddr[2])
                    lfo_pan_pkg::REG_PHASE_STEP:
                    begin
                        phase_step_reg <= pwdata[lfo_pan_pkg::PSTEP_W-1:0];
                    end
                    lfo_pan_pkg::REG_WIDTH:
                    begin
                        width_reg <= pwdata[lfo_pan_pkg::WIDTH_W-1:0];
                    end
                    default:
                    begin
                        width_reg <= width_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            sine_mag_reg <= sine_mag;
            sine_neg_reg <= sine_neg;
            l_neg_reg    <= left_in[SB-1];
            r_neg_reg    <= right_in[SB-1];
            l_mag_reg    <= left_in[SB-1] ? SB'(~left_in + 1'b1) : left_in;
            r_mag_reg    <= right_in[SB-1] ? SB'(~right_in + 1'b1) : right_in;
        end
        if (load_gain)
        begin
            gain_l_reg <= sine_neg_reg ? lfo_pan_pkg::GAIN_ONE
                                       : lfo_pan_pkg::GAIN_W'(lfo_pan_pkg::GAIN_ONE - pan_mag);
            gain_r_reg <= sine_neg_reg ? lfo_pan_pkg::GAIN_W'(lfo_pan_pkg::GAIN_ONE - pan_mag)
                                       : lfo_pan_pkg::GAIN_ONE;
        end
        if (load_out)
        begin
            out_data_reg <= lfo_pan_pkg::STREAM_W'({right_out, left_out});
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            lfo_pan_pkg::REG_PHASE_STEP:
            begin
                prdata = lfo_pan_pkg::DATA_W'(phase_step_reg);
            end
            lfo_pan_pkg::REG_WIDTH:
            begin
                prdata = lfo_pan_pkg::DATA_W'(width_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The right-channel multiply only ever runs alongside the left one.
    a_mul_b_with_a: assert property (@(posedge clk) disable iff (!rst_n)
        done_b |-> (done_a && state_reg == lfo_pan_pkg::ST_CH_WAIT))
        else $error("right multiplier finished out of step with the left one");

    // Each accepted pair advances the phase by exactly one step.
    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=>
        (phase_reg == lfo_pan_pkg::PHASE_BITS'($past(phase_reg)
                      + lfo_pan_pkg::PHASE_BITS'($past(phase_step_reg)))))
        else $error("phase did not advance by one step");

    // At most one channel is attenuated, and no gain exceeds unity.
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfo_pan_pkg::ST_CH_GO) |->
        ((gain_l_reg == lfo_pan_pkg::GAIN_ONE || gain_r_reg == lfo_pan_pkg::GAIN_ONE)
         && gain_l_reg <= lfo_pan_pkg::GAIN_ONE && gain_r_reg <= lfo_pan_pkg::GAIN_ONE))
        else $error("channel gains out of range");

    // A pending result is never overwritten before its transfer.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !load_out)
        else $error("pending output overwritten");

endmodule
